// ----- rtl/lcr_pkg.sv -----
// ----------------------------------------------------------------------------
// lcr_pkg: shared types for the line clipper
// Command and status groups between the clip controller and its datapath.
// ----------------------------------------------------------------------------
package lcr_pkg;

	typedef struct packed {
		logic load_in;
		logic load_ops;
		logic mul;
		logic div_start;
		logic update;
		logic finish;
		logic vis;
	} lcr_cmd_t;

	typedef struct packed {
		logic accept;
		logic reject;
		logic div_done;
	} lcr_status_t;

	localparam logic [1:0] REG_LEFT   = 2'd0;
	localparam logic [1:0] REG_TOP    = 2'd1;
	localparam logic [1:0] REG_RIGHT  = 2'd2;
	localparam logic [1:0] REG_BOTTOM = 2'd3;

endpackage

// ----- rtl/lcr_div.sv -----
// ----------------------------------------------------------------------------
// lcr_div: serial signed divider
// Restoring division, one quotient bit a cycle, truncating toward zero.
// A zero divisor gives a zero quotient. Only the low QW quotient bits leave.
// ----------------------------------------------------------------------------
module lcr_div #(
	parameter int DW = 34,
	parameter int VW = 17,
	parameter int QW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [QW-1:0] quot
);
	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dv_q;
	logic          neg_q;
	logic          zero_q;
	logic [VW:0]   shifted;
	logic          fits;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign fits    = shifted >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
			dv_q   <= divisor[VW-1] ? (~divisor + VW'(1)) : divisor;
			rem_q  <= '0;
			neg_q  <= dividend[DW-1] ^ divisor[VW-1];
			zero_q <= divisor == '0;
		end else if (busy_q) begin
			rem_q <= fits ? VW'(shifted - {1'b0, dv_q}) : shifted[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = zero_q ? '0 : (neg_q ? (~quo_q[QW-1:0] + QW'(1)) : quo_q[QW-1:0]);

endmodule

// ----- rtl/lcr_datapath.sv -----
// ----------------------------------------------------------------------------
// lcr_datapath: endpoint registers, outcodes and intersection arithmetic
// Holds the working segment, forms one edge intersection per round with a
// registered multiply and the serial divider, and keeps the result payload.
// ----------------------------------------------------------------------------
module lcr_datapath
	import lcr_pkg::*;
#(
	parameter int N = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lcr_cmd_t         cmd,
	output lcr_status_t      st,
	input  logic signed [N-1:0] left,
	input  logic signed [N-1:0] top,
	input  logic signed [N-1:0] right,
	input  logic signed [N-1:0] bottom,
	input  logic signed [N-1:0] in_sx,
	input  logic signed [N-1:0] in_sy,
	input  logic signed [N-1:0] in_ex,
	input  logic signed [N-1:0] in_ey,
	input  logic             in_check,
	output logic             out_vis,
	output logic [N-1:0]     out_sx,
	output logic [N-1:0]     out_sy,
	output logic [N-1:0]     out_ex,
	output logic [N-1:0]     out_ey
);
	localparam int PW = 2 * N + 2;

	logic signed [N-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [N-1:0] sx0_q, sy0_q, ex0_q, ey0_q;
	logic                check_q;
	logic [3:0]          ca, cb, c;
	logic signed [N-1:0] p_q, fix_q;
	logic signed [N:0]   dp_q, eq_q, dq_q;
	logic                horiz_q, side_b_q;
	logic signed [PW-1:0] prod_q;
	logic [N-1:0]        quot;
	logic [N-1:0]        newc;
	logic signed [N:0]   dxv, dyv;
	logic signed [N-1:0] edge_v;

	function automatic logic [3:0] outcode(input logic signed [N-1:0] x,
			input logic signed [N-1:0] y, input logic signed [N-1:0] l,
			input logic signed [N-1:0] t, input logic signed [N-1:0] r,
			input logic signed [N-1:0] b);
		logic [3:0] o;
		o = 4'd0;
		if (x < l) o[0] = 1'b1;
		else if (x > r) o[1] = 1'b1;
		if (y < t) o[2] = 1'b1;
		else if (y > b) o[3] = 1'b1;
		return o;
	endfunction

	assign ca = outcode(ax_q, ay_q, left, top, right, bottom);
	assign cb = outcode(bx_q, by_q, left, top, right, bottom);
	assign c  = (ca != 4'd0) ? ca : cb;
	assign st.accept = (ca == 4'd0) && (cb == 4'd0);
	assign st.reject = (ca & cb) != 4'd0;

	assign dxv = (N+1)'(bx_q) - (N+1)'(ax_q);
	assign dyv = (N+1)'(by_q) - (N+1)'(ay_q);

	// Edge picked by the highest set code bit: bottom, top, right, left.
	always_comb begin
		if (c[3]) edge_v = bottom;
		else if (c[2]) edge_v = top;
		else if (c[1]) edge_v = right;
		else edge_v = left;
	end

	lcr_div #(.DW(PW), .VW(N + 1), .QW(N)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (dq_q),
		.done     (st.div_done),
		.quot     (quot)
	);

	assign newc = p_q + quot;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ax_q <= in_sx; ay_q <= in_sy; bx_q <= in_ex; by_q <= in_ey;
			sx0_q <= in_sx; sy0_q <= in_sy; ex0_q <= in_ex; ey0_q <= in_ey;
			check_q <= in_check;
		end else if (cmd.update) begin
			if (side_b_q) begin
				bx_q <= horiz_q ? fix_q : newc;
				by_q <= horiz_q ? newc : fix_q;
			end else begin
				ax_q <= horiz_q ? fix_q : newc;
				ay_q <= horiz_q ? newc : fix_q;
			end
		end
		if (cmd.load_ops) begin
			side_b_q <= ca == 4'd0;
			horiz_q  <= !(c[3] || c[2]);
			fix_q    <= edge_v;
			if (c[3] || c[2]) begin
				p_q  <= ax_q;
				dp_q <= dxv;
				eq_q <= (N+1)'(edge_v) - (N+1)'(ay_q);
				dq_q <= dyv;
			end else begin
				p_q  <= ay_q;
				dp_q <= dyv;
				eq_q <= (N+1)'(edge_v) - (N+1)'(ax_q);
				dq_q <= dxv;
			end
		end
		if (cmd.mul) begin
			prod_q <= PW'(dp_q * eq_q);
		end
		if (cmd.finish) begin
			out_vis <= cmd.vis;
			if (cmd.vis && !check_q) begin
				out_sx <= ax_q; out_sy <= ay_q; out_ex <= bx_q; out_ey <= by_q;
			end else begin
				out_sx <= sx0_q; out_sy <= sy0_q; out_ex <= ex0_q; out_ey <= ey0_q;
			end
		end
	end

endmodule

// ----- rtl/lcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lcr_ctrl: clip round sequencer
// Steps each segment through outcode tests, intersection rounds and result
// hand-off, and owns both stream handshakes.
// ----------------------------------------------------------------------------
module lcr_ctrl
	import lcr_pkg::*;
#(
	parameter int MAX_ROUNDS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	output logic        m_tvalid,
	input  logic        m_tready,
	output lcr_cmd_t    cmd,
	input  lcr_status_t st
);
	localparam int RW = $clog2(MAX_ROUNDS + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EVAL   = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_DSTART = 3'd3;
	localparam logic [2:0] ST_DWAIT  = 3'd4;
	localparam logic [2:0] ST_UPD    = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	logic [2:0]    state_q, state_d;
	logic [RW-1:0] round_q;
	logic          vis_q, vis_d;
	logic          m_tvalid_q;
	logic          out_free;

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		vis_d   = vis_q;
		cmd     = '0;
		cmd.vis = vis_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (st.accept) begin
					vis_d = 1'b1;
					state_d = ST_FIN;
				end else if (st.reject || round_q == RW'(MAX_ROUNDS)) begin
					vis_d = 1'b0;
					state_d = ST_FIN;
				end else begin
					cmd.load_ops = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DSTART;
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_d = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (st.div_done) state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d = ST_EVAL;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			round_q    <= '0;
			vis_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vis_q   <= vis_d;
			if (cmd.load_in) round_q <= '0;
			else if (cmd.update) round_q <= round_q + RW'(1);
			if (cmd.finish) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_vis_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && cmd.vis) |-> st.accept)
		else $error("visible result without accepted outcodes");
	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		round_q <= RW'(MAX_ROUNDS))
		else $error("round counter past bound");
	a_load_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_EVAL && round_q == '0))
		else $error("accepted segment did not start evaluation");
	a_update_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> $past(st.div_done))
		else $error("endpoint update without divider result");
`endif

endmodule

// ----- rtl/line_clip_rect.sv -----
// Each segment takes R intersection rounds, R from 0 to MAX_ROUNDS, before its
// result is valid. A round steps through evaluate, multiply, divider start,
// the DW = 2*COORD_BITS + 2 divider steps and update; the serial divider, one
// quotient bit a cycle, sets the round length. Segments are taken one at a time.
// A finished result waits in the output register while the next segment is taken.
// Reset: arst_n clears control and loads the default clip rectangle.
// ----------------------------------------------------------------------------
// line_clip_rect: Cohen-Sutherland line clipper
// Clips segments against a rectangle set over the APB port.
// ----------------------------------------------------------------------------
module line_clip_rect
	import lcr_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int MAX_ROUNDS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	// start_x, start_y, end_x, end_y
	input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
	// check_only
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_start_x, out_start_y, out_end_x, out_end_y
	output logic [((4*COORD_BITS+7)/8)*8-1:0] m_tdata,
	// visible
	output logic        m_tuser
);
	localparam int N  = COORD_BITS;
	localparam int TW = ((4 * N + 7) / 8) * 8;

	logic [N-1:0] left_q, top_q, right_q, bottom_q;
	logic [N-1:0] osx, osy, oex, oey;
	logic         wr;
	lcr_cmd_t     cmd;
	lcr_status_t  st;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			right_q  <= N'(639);
			bottom_q <= N'(479);
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_LEFT:   left_q   <= pwdata[N-1:0];
				REG_TOP:    top_q    <= pwdata[N-1:0];
				REG_RIGHT:  right_q  <= pwdata[N-1:0];
				REG_BOTTOM: bottom_q <= pwdata[N-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LEFT:   prdata = 32'(left_q);
			REG_TOP:    prdata = 32'(top_q);
			REG_RIGHT:  prdata = 32'(right_q);
			REG_BOTTOM: prdata = 32'(bottom_q);
			default:    prdata = '0;
		endcase
	end

	lcr_ctrl #(.MAX_ROUNDS(MAX_ROUNDS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.st       (st)
	);

	lcr_datapath #(.N(N)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.left     (left_q),
		.top      (top_q),
		.right    (right_q),
		.bottom   (bottom_q),
		.in_sx    (s_tdata[N-1:0]),
		.in_sy    (s_tdata[2*N-1:N]),
		.in_ex    (s_tdata[3*N-1:2*N]),
		.in_ey    (s_tdata[4*N-1:3*N]),
		.in_check (s_tuser),
		.out_vis  (m_tuser),
		.out_sx   (osx),
		.out_sy   (osy),
		.out_ex   (oex),
		.out_ey   (oey)
	);

	assign m_tdata = TW'({oey, oex, osy, osx});

endmodule
